// ===== rtl/core/mrpmht_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpmht_pkg
// Shared types and constants of the multi-row prime-modulus hash table:
// operation codes, register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package mrpmht_pkg;

    localparam int KEY_W       = 32;
    localparam int PAYLOAD_W   = 32;
    localparam int MOD_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int ROW_CNT_W   = 3;
    localparam int ROW_IDX_W   = 2;
    localparam int SLOT_IDX_W  = 10;
    localparam int OCC_W       = 13;
    localparam int NUM_MOD_REGS = 4;

    typedef logic [1:0]       func_t;
    typedef logic [MOD_W-1:0] mod_t;

    localparam func_t FUNC_GET = 2'd0;
    localparam func_t FUNC_PUT = 2'd1;
    localparam func_t FUNC_ADD = 2'd2;
    localparam func_t FUNC_DEL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_ROW0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_ROW3   = 3'd4;

    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = 3'd4;
    localparam mod_t MOD_ROW0_RST = 11'd1021;
    localparam mod_t MOD_ROW1_RST = 11'd1019;
    localparam mod_t MOD_ROW2_RST = 11'd1013;
    localparam mod_t MOD_ROW3_RST = 11'd1009;

    // handshake between the sequencer and the serial modulo unit
    typedef struct packed {
        logic done;
        mod_t remainder;
    } mod_result_t;

endpackage

// ===== rtl/core/multi_row_prime_modulo_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// multi_row_prime_modulo_hash_table_core
// Hash table of up to four probed rows, each with its own prime modulus.
// Get, put, add and delete on 32-bit keys; key zero marks an empty slot.
//
//   channel   direction  handshake              fields
//   in        sink       in_valid / in_ready    func, lookup_key, payload
//   out       source     out_valid / out_ready  status, existed, row_index,
//                                               slot_index, value_out,
//                                               occupied_count
//   cfg       sink       cfg_write              cfg_index, cfg_data
//
// one item at a time; on the first walk each probed row takes a start, a 32-step
// serial modulo, a table read and a compare
// an add that misses walks the rows again from cached slots
// after reset the table is swept to zero, with in_ready low
// a finished result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module multi_row_prime_modulo_hash_table_core #(
    parameter int ROWS       = 4,
    parameter int ROW_DEPTH  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            func,
    input  logic [mrpmht_pkg::KEY_W-1:0]          lookup_key,
    input  logic [mrpmht_pkg::PAYLOAD_W-1:0]      payload,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  status,
    output logic                                  existed,
    output logic [mrpmht_pkg::ROW_IDX_W-1:0]      row_index,
    output logic [mrpmht_pkg::SLOT_IDX_W-1:0]     slot_index,
    output logic [mrpmht_pkg::PAYLOAD_W-1:0]      value_out,
    output logic [mrpmht_pkg::OCC_W-1:0]          occupied_count,

    input  logic                                  cfg_write,
    input  logic [mrpmht_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrpmht_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TOTAL   = ROWS * ROW_DEPTH;
    localparam int ADDR_W  = $clog2(TOTAL);
    localparam int SLOT_W  = $clog2(ROW_DEPTH);
    localparam int CNT_W   = $clog2(TOTAL + 1);
    localparam int KEY_W   = mrpmht_pkg::KEY_W;
    localparam int MOD_W   = mrpmht_pkg::MOD_W;
    localparam int ENTRY_W = KEY_W + VALUE_BITS;
    localparam int RW      = mrpmht_pkg::ROW_IDX_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MODW  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // control state
    logic [2:0]                         state_reg, state_next;
    logic [ADDR_W-1:0]                  clr_cnt_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [mrpmht_pkg::ROW_CNT_W-1:0]   row_count_reg;
    mrpmht_pkg::mod_t                   mod_reg [mrpmht_pkg::NUM_MOD_REGS];
    logic                               out_valid_reg;

    // item and result registers
    mrpmht_pkg::func_t                  func_reg;
    logic [KEY_W-1:0]                   key_reg;
    logic [VALUE_BITS-1:0]              pay_reg;
    logic [RW-1:0]                      row_reg;
    logic [SLOT_W-1:0]                  slot_reg;
    logic [SLOT_W-1:0]                  slot_cache [mrpmht_pkg::NUM_MOD_REGS];
    logic                               phase_zero_reg;
    logic                               second_pass_reg;
    logic                               res_status_reg;
    logic                               res_existed_reg;
    logic [VALUE_BITS-1:0]              res_val_reg;

    logic                               status_reg;
    logic                               existed_reg;
    logic [RW-1:0]                      row_out_reg;
    logic [SLOT_W-1:0]                  slot_out_reg;
    logic [VALUE_BITS-1:0]              val_out_reg;
    logic [CNT_W-1:0]                   occ_out_reg;

    // datapath
    logic                               in_xfer;
    logic                               out_load;
    logic [2:0]                         rows_used;
    logic [RW-1:0]                      next_row;
    logic                               more_rows;
    logic [RW-1:0]                      mod_row_sel;
    mrpmht_pkg::mod_t                   mod_raw;
    mrpmht_pkg::mod_t                   mod_eff;
    logic                               mod_start;
    logic [KEY_W-1:0]                   mod_dividend;
    mrpmht_pkg::mod_result_t            mod_res;
    logic [SLOT_W+MOD_W-1:0]            rem_ext;
    logic [SLOT_W-1:0]                  rem_slot;
    logic [31:0]                        probe_sum;
    logic [ADDR_W-1:0]                  probe_addr;
    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_addr;
    logic [ENTRY_W-1:0]                 ram_wdata;
    logic [ENTRY_W-1:0]                 ram_rdata;
    logic [KEY_W-1:0]                   rd_key;
    logic [VALUE_BITS-1:0]              rd_val;
    logic                               hit;
    logic                               write_entry;
    logic                               clear_entry;
    logic                               start_miss;
    logic [VALUE_BITS+KEY_W-1:0]        pay_ext;
    logic [VALUE_BITS+KEY_W-1:0]        val_ext;
    logic [SLOT_W+mrpmht_pkg::SLOT_IDX_W-1:0] slot_ext;
    logic [CNT_W+mrpmht_pkg::OCC_W-1:0]  occ_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // rows probed: row_count limited by ROWS and by the modulus registers
    always_comb
    begin
        rows_used = row_count_reg;
        if (32'(row_count_reg) > ROWS)
        begin
            rows_used = 3'(ROWS);
        end
        if (rows_used > 3'(mrpmht_pkg::NUM_MOD_REGS))
        begin
            rows_used = 3'(mrpmht_pkg::NUM_MOD_REGS);
        end
    end

    assign next_row  = row_reg + 1'b1;
    assign more_rows = ({1'b0, row_reg} + 3'd1) < rows_used;

    // modulus of the row about to be probed, clamped to 1 .. ROW_DEPTH
    always_comb
    begin
        mod_row_sel = (state_reg == S_IDLE) ? '0 : next_row;
        mod_raw     = mod_reg[mod_row_sel];
        mod_eff     = mod_raw;
        if (mod_raw == '0)
        begin
            mod_eff = MOD_W'(1);
        end
        else if (32'(mod_raw) > ROW_DEPTH)
        begin
            mod_eff = MOD_W'(ROW_DEPTH);
        end
    end

    assign start_miss   = (lookup_key == '0) || (rows_used == '0);
    assign mod_dividend = (state_reg == S_IDLE) ? lookup_key : key_reg;

    mrpmht_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_eff),
        .result   (mod_res)
    );

    assign rem_ext  = {{SLOT_W{1'b0}}, mod_res.remainder};
    assign rem_slot = rem_ext[SLOT_W-1:0];

    assign probe_sum  = 32'(row_reg) * 32'(ROW_DEPTH) + 32'(slot_reg);
    assign probe_addr = probe_sum[ADDR_W-1:0];

    assign rd_key = ram_rdata[ENTRY_W-1:VALUE_BITS];
    assign rd_val = ram_rdata[VALUE_BITS-1:0];
    assign hit    = (rd_key == (phase_zero_reg ? '0 : key_reg));

    assign write_entry = (state_reg == S_CHECK) && hit && phase_zero_reg;
    assign clear_entry = (state_reg == S_CHECK) && hit && !phase_zero_reg
                         && (func_reg == mrpmht_pkg::FUNC_DEL);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = probe_addr;
        ram_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_cnt_reg;
        end
        else if (write_entry)
        begin
            ram_we    = 1'b1;
            ram_wdata = {key_reg, pay_reg};
        end
        else if (clear_entry)
        begin
            ram_we = 1'b1;
        end
    end

    mrpmht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        mod_start  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (start_miss)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MODW;
                    end
                end
            end
            S_MODW:
            begin
                if (mod_res.done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    state_next = S_OUT;
                end
                else if (more_rows)
                begin
                    if (second_pass_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MODW;
                    end
                end
                else if (!phase_zero_reg && (func_reg == mrpmht_pkg::FUNC_ADD))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            row_count_reg <= mrpmht_pkg::ROW_COUNT_RST;
            mod_reg[0]    <= mrpmht_pkg::MOD_ROW0_RST;
            mod_reg[1]    <= mrpmht_pkg::MOD_ROW1_RST;
            mod_reg[2]    <= mrpmht_pkg::MOD_ROW2_RST;
            mod_reg[3]    <= mrpmht_pkg::MOD_ROW3_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (write_entry)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (clear_entry && (count_reg != '0))
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                if (cfg_index == mrpmht_pkg::REG_ROW_COUNT)
                begin
                    row_count_reg <= cfg_data[mrpmht_pkg::ROW_CNT_W-1:0];
                end
                else if ((cfg_index >= mrpmht_pkg::REG_MOD_ROW0)
                         && (cfg_index <= mrpmht_pkg::REG_MOD_ROW3)
                         && (32'(cfg_index - mrpmht_pkg::REG_MOD_ROW0) < ROWS))
                begin
                    mod_reg[RW'(cfg_index - mrpmht_pkg::REG_MOD_ROW0)] <= cfg_data;
                end
            end
        end
    end

    assign pay_ext = {{VALUE_BITS{1'b0}}, payload};

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    func_reg        <= func;
                    key_reg         <= lookup_key;
                    pay_reg         <= pay_ext[VALUE_BITS-1:0];
                    row_reg         <= '0;
                    slot_reg        <= '0;
                    phase_zero_reg  <= (func == mrpmht_pkg::FUNC_PUT);
                    second_pass_reg <= 1'b0;
                    res_status_reg  <= 1'b1;
                    res_existed_reg <= 1'b0;
                    res_val_reg     <= '0;
                end
            end
            S_MODW:
            begin
                if (mod_res.done)
                begin
                    slot_reg            <= rem_slot;
                    slot_cache[row_reg] <= rem_slot;
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    res_status_reg  <= 1'b0;
                    res_existed_reg <= !phase_zero_reg
                                       && (func_reg == mrpmht_pkg::FUNC_ADD);
                    res_val_reg     <= phase_zero_reg ? pay_reg : rd_val;
                end
                else if (more_rows)
                begin
                    row_reg <= next_row;
                    if (second_pass_reg)
                    begin
                        slot_reg <= slot_cache[next_row];
                    end
                end
                else if (!phase_zero_reg && (func_reg == mrpmht_pkg::FUNC_ADD))
                begin
                    // key absent: walk the rows again looking for an empty slot
                    phase_zero_reg  <= 1'b1;
                    second_pass_reg <= 1'b1;
                    row_reg         <= '0;
                    slot_reg        <= slot_cache[0];
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            status_reg   <= res_status_reg;
            existed_reg  <= res_existed_reg;
            row_out_reg  <= res_status_reg ? '0 : row_reg;
            slot_out_reg <= res_status_reg ? '0 : slot_reg;
            val_out_reg  <= res_val_reg;
            occ_out_reg  <= count_reg;
        end
    end

    assign val_ext  = {{KEY_W{1'b0}}, val_out_reg};
    assign slot_ext = {{mrpmht_pkg::SLOT_IDX_W{1'b0}}, slot_out_reg};
    assign occ_ext  = {{mrpmht_pkg::OCC_W{1'b0}}, occ_out_reg};

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign existed        = existed_reg;
    assign row_index      = row_out_reg;
    assign slot_index     = slot_ext[mrpmht_pkg::SLOT_IDX_W-1:0];
    assign value_out      = val_ext[mrpmht_pkg::PAYLOAD_W-1:0];
    assign occupied_count = occ_ext[mrpmht_pkg::OCC_W-1:0];

    // modulo results only arrive while the sequencer waits for them
    a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_res.done |-> (state_reg == S_MODW))
        else $error("modulo result outside wait state");

    // a put only ever lands on an empty slot
    a_put_over_empty: assert property (@(posedge clk) disable iff (!rst_n)
        write_entry |-> (rd_key == '0))
        else $error("put overwrote an occupied slot");

    // the occupancy count moves only on a table write
    a_count_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_CHECK))
        else $error("occupancy count changed outside a table write");

    // an accepted item always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("input transfer did not start a lookup");

endmodule

// ===== rtl/core/mrpmht_ram.sv =====
// ----------------------------------------------------------------------------
// mrpmht_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module mrpmht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mrpmht_mod.sv =====
// ----------------------------------------------------------------------------
// mrpmht_mod
// Serial 32-bit modulo by an 11-bit divisor, restoring, one dividend bit a
// cycle. The remainder is valid with the done pulse.
// ----------------------------------------------------------------------------
module mrpmht_mod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mrpmht_pkg::KEY_W-1:0] dividend,
    input  mrpmht_pkg::mod_t         divisor,
    output mrpmht_pkg::mod_result_t  result
);

    localparam int STEP_W = $clog2(mrpmht_pkg::KEY_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [mrpmht_pkg::KEY_W-1:0] shift_reg;
    mrpmht_pkg::mod_t             rem_reg;
    mrpmht_pkg::mod_t             div_reg;

    logic [mrpmht_pkg::MOD_W:0]   trial;
    logic [mrpmht_pkg::MOD_W:0]   diff;
    mrpmht_pkg::mod_t             rem_next;
    logic                         last_step;

    always_comb
    begin
        trial     = {rem_reg, shift_reg[mrpmht_pkg::KEY_W-1]};
        diff      = trial - {1'b0, div_reg};
        rem_next  = (trial >= {1'b0, div_reg}) ? diff[mrpmht_pkg::MOD_W-1:0]
                                               : trial[mrpmht_pkg::MOD_W-1:0];
        last_step = (step_reg == STEP_W'(mrpmht_pkg::KEY_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[mrpmht_pkg::KEY_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign result.done      = done_reg;
    assign result.remainder = rem_reg;

endmodule

// ===== tb/multi_row_prime_modulo_hash_table_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_row_prime_modulo_hash_table_core_test
// Self-checking bench for the prime-modulus hash table. A mirror of the table
// predicts status, location, value and occupancy of every get, put, add and
// delete. It runs a directed opening, then random traffic over small key
// pools under several row counts and moduli, from degenerate to oversized.
// ----------------------------------------------------------------------------
module multi_row_prime_modulo_hash_table_core_test;

    localparam int KEY_W        = mrpmht_pkg::KEY_W;
    localparam int PAYLOAD_W    = mrpmht_pkg::PAYLOAD_W;
    localparam int MOD_W        = mrpmht_pkg::MOD_W;
    localparam int CFG_IDX_W    = mrpmht_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = mrpmht_pkg::CFG_DATA_W;
    localparam int ROW_CNT_W    = mrpmht_pkg::ROW_CNT_W;
    localparam int ROW_IDX_W    = mrpmht_pkg::ROW_IDX_W;
    localparam int SLOT_IDX_W   = mrpmht_pkg::SLOT_IDX_W;
    localparam int OCC_W        = mrpmht_pkg::OCC_W;
    localparam int NUM_MOD_REGS = mrpmht_pkg::NUM_MOD_REGS;

    localparam int TABLE_ROWS  = 4;
    localparam int ROW_SLOTS   = 1024;
    localparam int ITEM_CYCLES = 4 * 35 + 2 + 4 * 2;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic                  status;
        logic                  existed;
        logic [ROW_IDX_W-1:0]  row;
        logic [SLOT_IDX_W-1:0] slot;
        logic [PAYLOAD_W-1:0]  value;
        logic [OCC_W-1:0]      occ;
    } table_result_t;

    // mirror of the table contents and registers
    class hash_table_scoreboard;
        bit [KEY_W-1:0]     key_mem[TABLE_ROWS * ROW_SLOTS];
        bit [PAYLOAD_W-1:0] val_mem[TABLE_ROWS * ROW_SLOTS];
        int unsigned        occupancy;
        bit [ROW_CNT_W-1:0] row_cnt;
        bit [MOD_W-1:0]     modulus[NUM_MOD_REGS];
        table_result_t      expected_q[$];
        int unsigned        errors;
        int unsigned        n_checked;
        int unsigned        n_hits;
        int unsigned        n_stored;
        int unsigned        n_existed;
        int unsigned        n_refused;

        function new();
            foreach (key_mem[i])
            begin
                key_mem[i] = '0;
                val_mem[i] = '0;
            end
            occupancy  = 0;
            row_cnt    = mrpmht_pkg::ROW_COUNT_RST;
            modulus[0] = mrpmht_pkg::MOD_ROW0_RST;
            modulus[1] = mrpmht_pkg::MOD_ROW1_RST;
            modulus[2] = mrpmht_pkg::MOD_ROW2_RST;
            modulus[3] = mrpmht_pkg::MOD_ROW3_RST;
            errors     = 0;
            n_checked  = 0;
            n_hits     = 0;
            n_stored   = 0;
            n_existed  = 0;
            n_refused  = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == mrpmht_pkg::REG_ROW_COUNT)
                row_cnt = data[ROW_CNT_W-1:0];
            else if (idx >= mrpmht_pkg::REG_MOD_ROW0 && idx <= mrpmht_pkg::REG_MOD_ROW3)
                modulus[idx - mrpmht_pkg::REG_MOD_ROW0] = data;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // first probed row whose slot holds want
        function bit locate(input bit [KEY_W-1:0] key, input bit [KEY_W-1:0] want,
                            output bit [ROW_IDX_W-1:0] row,
                            output bit [SLOT_IDX_W-1:0] slot, output int unsigned addr);
            int unsigned rows;
            int unsigned m;
            int unsigned s;
            rows = (row_cnt > TABLE_ROWS) ? TABLE_ROWS : row_cnt;
            row  = '0;
            slot = '0;
            addr = 0;
            for (int r = 0; r < rows; r++)
            begin
                m = modulus[r];
                if (m == 0)
                    m = 1;
                if (m > ROW_SLOTS)
                    m = ROW_SLOTS;
                s = key % m;
                if (key_mem[r * ROW_SLOTS + s] == want)
                begin
                    row  = r[ROW_IDX_W-1:0];
                    slot = s[SLOT_IDX_W-1:0];
                    addr = r * ROW_SLOTS + s;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_input(mrpmht_pkg::func_t op, bit [KEY_W-1:0] key,
                                 bit [PAYLOAD_W-1:0] pay);
            table_result_t       r;
            bit [ROW_IDX_W-1:0]  row;
            bit [SLOT_IDX_W-1:0] slot;
            int unsigned         addr;
            bit                  do_put;
            r        = '0;
            r.status = 1'b1;
            do_put   = 1'b0;
            if (key != '0)
            begin
                if (op == mrpmht_pkg::FUNC_PUT)
                    do_put = 1'b1;
                else if (locate(key, key, row, slot, addr))
                begin
                    r.status = 1'b0;
                    r.row    = row;
                    r.slot   = slot;
                    r.value  = val_mem[addr];
                    n_hits++;
                    if (op == mrpmht_pkg::FUNC_ADD)
                    begin
                        r.existed = 1'b1;
                        n_existed++;
                    end
                    else if (op == mrpmht_pkg::FUNC_DEL)
                    begin
                        key_mem[addr] = '0;
                        val_mem[addr] = '0;
                        if (occupancy > 0)
                            occupancy--;
                    end
                end
                else if (op == mrpmht_pkg::FUNC_ADD)
                    do_put = 1'b1;
            end
            if (do_put && locate(key, '0, row, slot, addr))
            begin
                key_mem[addr] = key;
                val_mem[addr] = pay;
                occupancy++;
                r.status = 1'b0;
                r.row    = row;
                r.slot   = slot;
                r.value  = pay;
                n_stored++;
            end
            if (r.status)
            begin
                r       = '0;
                r.status = 1'b1;
                n_refused++;
            end
            r.occ = occupancy[OCC_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t exp;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing outstanding");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            n_checked++;
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.existed !== exp.existed)
            begin
                $error("existed: expected %0d, got %0d", exp.existed, got.existed);
                errors++;
            end
            if (got.row !== exp.row)
            begin
                $error("row_index: expected %0d, got %0d", exp.row, got.row);
                errors++;
            end
            if (got.slot !== exp.slot)
            begin
                $error("slot_index: expected %0d, got %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.value !== exp.value)
            begin
                $error("value_out: expected %h, got %h", exp.value, got.value);
                errors++;
            end
            if (got.occ !== exp.occ)
            begin
                $error("occupied_count: expected %0d, got %0d", exp.occ, got.occ);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            func = mrpmht_pkg::FUNC_GET;
    logic [KEY_W-1:0]      lookup_key = '0;
    logic [PAYLOAD_W-1:0]  payload = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  status;
    logic                  existed;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [PAYLOAD_W-1:0]  value_out;
    logic [OCC_W-1:0]      occupied_count;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    hash_table_scoreboard  sb = new();
    bit                    steady = 1'b0;
    int unsigned           stall_cycles = 0;
    int unsigned           n_configs = 1;
    bit [KEY_W-1:0]        key_pool[$];

    multi_row_prime_modulo_hash_table_core #(
        .ROWS       (TABLE_ROWS),
        .ROW_DEPTH  (ROW_SLOTS),
        .VALUE_BITS (PAYLOAD_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .lookup_key     (lookup_key),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .existed        (existed),
        .row_index      (row_index),
        .slot_index     (slot_index),
        .value_out      (value_out),
        .occupied_count (occupied_count),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 19);
    end

    // input transfer noted before the output check, so the older item pops first
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_input(mrpmht_pkg::func_t'(func), lookup_key, payload);
        if (out_valid && out_ready)
            sb.check_result('{status, existed, row_index, slot_index, value_out,
                              occupied_count});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("** multi_row_prime_modulo_hash_table_core: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(mrpmht_pkg::func_t op, bit [KEY_W-1:0] key,
                             bit [PAYLOAD_W-1:0] pay);
        while (!steady && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        lookup_key <= key;
        payload    <= pay;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(bit [CFG_DATA_W-1:0] rows, bit [CFG_DATA_W-1:0] m0,
                              bit [CFG_DATA_W-1:0] m1, bit [CFG_DATA_W-1:0] m2,
                              bit [CFG_DATA_W-1:0] m3);
        bit [CFG_DATA_W-1:0] vals[5];
        bit [CFG_IDX_W-1:0]  idx;
        vals = '{rows, m0, m1, m2, m3};
        for (int i = 0; i < 5; i++)
        begin
            idx = (i == 0) ? mrpmht_pkg::REG_ROW_COUNT
                           : CFG_IDX_W'(mrpmht_pkg::REG_MOD_ROW0 + i - 1);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            sb.write_reg(idx, vals[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        n_configs++;
    endtask

    // mix of wide random keys, keys colliding on row 0 and low-valued keys
    function automatic void build_pool(int n);
        bit [KEY_W-1:0] k;
        int unsigned    m;
        key_pool.delete();
        m = (sb.modulus[0] == 0) ? 1 : sb.modulus[0];
        for (int i = 0; i < n; i++)
        begin
            case (i % 4)
                0, 1:    k = $urandom;
                2:       k = key_pool[i - 1] + m * $urandom_range(1, 3);
                default: k = $urandom_range(1, 5000);
            endcase
            if (k == '0)
                k = 32'd1;
            key_pool.push_back(k);
        end
    endfunction

    task automatic run_random(int count, int pool_size, bit pause_midway);
        int                pick;
        mrpmht_pkg::func_t op;
        bit [KEY_W-1:0]    key;
        build_pool(pool_size);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_for_results();
            pick = $urandom_range(0, 99);
            op   = (pick < 30) ? mrpmht_pkg::FUNC_GET :
                   (pick < 55) ? mrpmht_pkg::FUNC_PUT :
                   (pick < 80) ? mrpmht_pkg::FUNC_ADD : mrpmht_pkg::FUNC_DEL;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                key = '0;
            else if (pick < 13)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_item(op, key, $urandom);
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // table sweep after reset holds in_ready low
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        // zero key on every operation, then hits, duplicates and deletes
        send_item(mrpmht_pkg::FUNC_GET, 32'd0, 32'd0);
        send_item(mrpmht_pkg::FUNC_PUT, 32'd0, 32'hFFFF_FFFF);
        send_item(mrpmht_pkg::FUNC_ADD, 32'd0, 32'hFFFF_FFFF);
        send_item(mrpmht_pkg::FUNC_DEL, 32'd0, 32'd0);
        send_item(mrpmht_pkg::FUNC_GET, 32'd5, 32'd0);
        send_item(mrpmht_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(mrpmht_pkg::FUNC_PUT, 32'd1, 32'd0);
        send_item(mrpmht_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'd0);
        send_item(mrpmht_pkg::FUNC_ADD, 32'd1, 32'hAAAA_5555);
        send_item(mrpmht_pkg::FUNC_ADD, 32'd2, 32'h5555_AAAA);
        send_item(mrpmht_pkg::FUNC_PUT, 32'd1, 32'h1234_5678);
        send_item(mrpmht_pkg::FUNC_DEL, 32'd1, 32'd0);
        send_item(mrpmht_pkg::FUNC_GET, 32'd1, 32'd0);
        send_item(mrpmht_pkg::FUNC_DEL, 32'd1, 32'd0);
        send_item(mrpmht_pkg::FUNC_DEL, 32'd1, 32'd0);
        send_item(mrpmht_pkg::FUNC_PUT, 32'd1022, 32'h8000_0001);
        wait_for_results();

        // one slot per row: the rows fill and puts get refused
        set_config(11'd4, 11'd1, 11'd1, 11'd1, 11'd1);
        for (int i = 10; i < 15; i++)
            send_item(mrpmht_pkg::FUNC_PUT, i, $urandom);
        send_item(mrpmht_pkg::FUNC_ADD, 32'd15, 32'h0F0F_0F0F);
        send_item(mrpmht_pkg::FUNC_GET, 32'd12, 32'd0);
        send_item(mrpmht_pkg::FUNC_DEL, 32'd10, 32'd0);
        wait_for_results();

        // no rows probed
        set_config(11'd0, 11'd1, 11'd1, 11'd1, 11'd1);
        send_item(mrpmht_pkg::FUNC_GET, 32'd11, 32'd0);
        send_item(mrpmht_pkg::FUNC_PUT, 32'd16, 32'd1);
        wait_for_results();

        set_config(11'd4, mrpmht_pkg::MOD_ROW0_RST, mrpmht_pkg::MOD_ROW1_RST,
                   mrpmht_pkg::MOD_ROW2_RST, mrpmht_pkg::MOD_ROW3_RST);
        run_random(170, 24, 1'b1);

        set_config(11'd4, 11'd3, 11'd2, 11'd1, 11'd0);
        run_random(140, 16, 1'b0);

        // oversized moduli and row count, back-to-back on both sides
        steady = 1'b1;
        set_config(11'd7, 11'd2047, 11'd1024, 11'd1, 11'd5);
        run_random(150, 24, 1'b0);
        steady = 1'b0;

        set_config(11'd0, mrpmht_pkg::MOD_ROW0_RST, mrpmht_pkg::MOD_ROW1_RST,
                   mrpmht_pkg::MOD_ROW2_RST, mrpmht_pkg::MOD_ROW3_RST);
        run_random(30, 16, 1'b0);

        set_config(11'd2, 11'd7, 11'd11, 11'd13, 11'd17);
        run_random(140, 20, 1'b0);

        // bits above the row count field are dropped
        set_config(11'h7F9, 11'd1024, 11'd2, 11'd3, 11'd5);
        run_random(120, 24, 1'b0);

        repeat (ITEM_CYCLES) @(posedge clk);

        $display("%0d results checked over %0d register settings", sb.n_checked, n_configs);
        $display("%0d found, %0d stored, %0d add on present key, %0d miss or no free slot",
                 sb.n_hits, sb.n_stored, sb.n_existed, sb.n_refused);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** multi_row_prime_modulo_hash_table_core: PASSED **");
        else
            $display("** multi_row_prime_modulo_hash_table_core: FAILED **");
        $finish;
    end

endmodule
